// File: src/priority_round_robin_picker_core_macros.svh
// assertion macros for the priority round-robin picker
// no dependencies; included by the top level only
`ifndef PRIORITY_ROUND_ROBIN_PICKER_CORE_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_PICKER_CORE_MACROS_SVH

// clocked check, muted while reset is asserted
`define PRRP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("prrp check failed");

// clocked check that also holds through reset
`define PRRP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("prrp check failed");

`endif

// File: src/prrp_pkg.sv
// shared types and constants for the priority round-robin picker
// no dependencies
`default_nettype none

package prrp_pkg;

    localparam int LVL_W  = 5;
    localparam int SLOT_W = 4;

    // one slot entry as read from the table
    typedef struct packed {
        logic             ready;
        logic [LVL_W-1:0] level;
    } entry_t;

    // table write request
    typedef struct packed {
        logic             en;
        logic             ready;
        logic [LVL_W-1:0] level;
    } wr_req_t;

    // one finished selection
    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot;
        logic [LVL_W-1:0]  level;
    } result_t;

endpackage

`default_nettype wire

// File: src/prrp_table.sv
// slot table: ready flags in flops, levels in a small memory, one registered read port
// depends on prrp_pkg
`default_nettype none

module prrp_table #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire prrp_pkg::wr_req_t     wr_req,
    input  wire logic [IDX_W-1:0]      wr_idx,
    input  wire logic [IDX_W-1:0]      rd_addr,
    output prrp_pkg::entry_t           rd_data
);

    logic [SLOTS-1:0]           ready_reg;
    logic [prrp_pkg::LVL_W-1:0] level_mem [SLOTS];
    prrp_pkg::entry_t           rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg <= '0;
        end else if (wr_req.en) begin
            ready_reg[wr_idx] <= wr_req.ready;
        end
    end

    // level of a never-written slot is only looked at when its ready flag is set
    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            level_mem[wr_idx] <= wr_req.level;
        end
        rd_data_reg.ready <= ready_reg[rd_addr];
        rd_data_reg.level <= level_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/prrp_seq.sv
// scan sequencer: walks the slot table one entry a cycle through a shared level comparator
// depends on prrp_pkg
`default_nettype none

module prrp_seq #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic                  keep_in,
    input  wire logic                  out_free,
    input  wire prrp_pkg::entry_t      rd_data,
    output logic [IDX_W-1:0]           rd_addr,
    output logic                       busy,
    output logic                       done,
    output prrp_pkg::result_t          result
);

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           cur_slot_reg, cur_slot_next;
    logic                       cur_valid_reg, cur_valid_next;
    logic                       keep_reg, keep_next;
    logic                       have_reg, have_next;
    logic [IDX_W-1:0]           win_reg, win_next;
    logic [prrp_pkg::LVL_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]           scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]           issued_reg, issued_next;
    logic                       tag_vld_reg, tag_vld_next;
    logic                       tag_keep_reg, tag_keep_next;
    logic [IDX_W-1:0]           tag_idx_reg, tag_idx_next;
    logic                       issue;
    logic                       better;
    logic [31:0]                win_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            tag_vld_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            tag_vld_reg   <= tag_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        keep_reg     <= keep_next;
        have_reg     <= have_next;
        win_reg      <= win_next;
        best_reg     <= best_next;
        scan_idx_reg <= scan_idx_next;
        issued_reg   <= issued_next;
        tag_keep_reg <= tag_keep_next;
        tag_idx_reg  <= tag_idx_next;
    end

    // the one comparator: strict less-than so earlier slots keep ties
    assign better = !have_reg || (rd_data.level < best_reg);
    assign issue  = (issued_reg != CNT_FULL);

    always_comb begin
        state_next     = state_reg;
        cur_slot_next  = cur_slot_reg;
        cur_valid_next = cur_valid_reg;
        keep_next      = keep_reg;
        have_next      = have_reg;
        win_next       = win_reg;
        best_next      = best_reg;
        scan_idx_next  = scan_idx_reg;
        issued_next    = issued_reg;
        tag_vld_next   = 1'b0;
        tag_keep_next  = tag_keep_reg;
        tag_idx_next   = tag_idx_reg;
        rd_addr        = scan_idx_reg;
        done           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                // first read fetches the current slot for the keep check
                rd_addr = cur_slot_reg;
                if (start) begin
                    keep_next     = keep_in;
                    have_next     = 1'b0;
                    win_next      = '0;
                    best_next     = '0;
                    issued_next   = '0;
                    tag_vld_next  = 1'b1;
                    tag_keep_next = 1'b1;
                    if (!cur_valid_reg || cur_slot_reg == LAST_IDX) begin
                        scan_idx_next = '0;
                    end else begin
                        scan_idx_next = cur_slot_reg + 1'b1;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    issued_next   = issued_reg + 1'b1;
                    scan_idx_next = (scan_idx_reg == LAST_IDX) ? '0 : scan_idx_reg + 1'b1;
                    tag_vld_next  = 1'b1;
                    tag_keep_next = 1'b0;
                    tag_idx_next  = scan_idx_reg;
                end
                if (tag_vld_reg) begin
                    if (tag_keep_reg) begin
                        if (keep_reg && cur_valid_reg && rd_data.ready) begin
                            have_next = 1'b1;
                            win_next  = cur_slot_reg;
                            best_next = rd_data.level;
                        end
                    end else if (rd_data.ready
                                 && !(keep_reg && cur_valid_reg && tag_idx_reg == cur_slot_reg)
                                 && better) begin
                        have_next = 1'b1;
                        win_next  = tag_idx_reg;
                        best_next = rd_data.level;
                    end
                end
                if (!issue && !tag_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    done = 1'b1;
                    if (have_reg) begin
                        cur_slot_next  = win_reg;
                        cur_valid_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign win_ext        = 32'(win_reg);
    assign busy           = (state_reg != ST_IDLE);
    assign result.granted = have_reg;
    assign result.slot    = have_reg ? win_ext[prrp_pkg::SLOT_W-1:0] : '0;
    assign result.level   = have_reg ? best_reg : '0;

endmodule

`default_nettype wire

// File: src/priority_round_robin_picker_core.sv
// priority picker with round-robin tie break over a table of SLOTS slots
// update request: written in the accept cycle, ready again on the next cycle, no result
// select request: one table read a cycle through the single table read port, then a registered result
// no new request is taken until a select has passed scan, read drain and result load back to idle,
// and the wait is longer while a finished result waits on m_tready
// reset: synchronous active-low aresetn clears all ready flags and the current slot
`default_nettype none
`include "priority_round_robin_picker_core_macros.svh"

module priority_round_robin_picker_core #(
    parameter int SLOTS  = 16,
    parameter int LEVELS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // slot[3:0], ready_req[4], level[9:5], keep_current[10]
    input  wire logic [0:0]  s_tuser,   // op[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // grant_slot[3:0], grant_level[8:4]
    output logic [0:0]       m_tuser    // granted[0]
);

    localparam int IDX_W = $clog2(SLOTS);

    logic                       s_accept;
    logic                       busy;
    logic                       done;
    logic                       out_free;
    logic [31:0]                slot_ext;
    logic [31:0]                level_ext;
    logic [IDX_W-1:0]           wr_idx;
    logic [IDX_W-1:0]           rd_addr;
    prrp_pkg::wr_req_t          wr_req;
    prrp_pkg::entry_t           rd_data;
    prrp_pkg::result_t          result;
    logic                       m_tvalid_reg, m_tvalid_next;
    prrp_pkg::result_t          out_reg, out_next;

    assign s_tready = !busy;
    assign s_accept = s_tvalid && s_tready;

    assign slot_ext  = 32'(s_tdata[3:0]);
    assign level_ext = 32'(s_tdata[9:5]);
    assign wr_idx    = slot_ext[IDX_W-1:0];

    // out-of-range slots are dropped, out-of-range levels saturate
    always_comb begin
        wr_req.en    = s_accept && !s_tuser[0] && (slot_ext < 32'(SLOTS));
        wr_req.ready = s_tdata[4];
        wr_req.level = (level_ext >= 32'(LEVELS)) ? prrp_pkg::LVL_W'(LEVELS - 1)
                                                  : s_tdata[9:5];
    end

    prrp_table #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_req  (wr_req),
        .wr_idx  (wr_idx),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    prrp_seq #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept && s_tuser[0]),
        .keep_in  (s_tdata[10]),
        .out_free (out_free),
        .rd_data  (rd_data),
        .rd_addr  (rd_addr),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (done) begin
            m_tvalid_next = 1'b1;
            out_next      = result;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.granted;
    assign m_tdata  = {7'd0, out_reg.level, out_reg.slot};

    // a select request keeps the input closed on the next cycle
    `PRRP_ASSERT(a_select_blocks, aclk, aresetn, (s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
    // an update request never produces a result
    `PRRP_ASSERT(a_update_silent, aclk, aresetn, (s_tvalid && s_tready && !s_tuser[0]) |=> !$rose(m_tvalid))
    // no grant means zero slot and level
    `PRRP_ASSERT(a_nogrant_zero, aclk, aresetn, (m_tvalid && !m_tuser[0]) |-> (m_tdata == 16'd0))
    // the result register never loads while its contents are still offered
    `PRRP_ASSERT_ALWAYS(a_no_overwrite, aclk, (m_tvalid && !m_tready && aresetn) |=> ($stable(m_tdata) || !aresetn))

endmodule

`default_nettype wire

// File: tb/tb_priority_round_robin_picker_core.sv
// self-checking testbench for priority_round_robin_picker_core: directed and random
// slot updates and selections, checked against a built-in predictor of the slot table
// depends on prrp_pkg and priority_round_robin_picker_core
`timescale 1ns / 100ps

module tb_priority_round_robin_picker_core;

    localparam int          NUM_SLOTS  = 16;
    localparam int          ITEM_GOAL  = 1950;
    localparam int          SELECT_LAT = NUM_SLOTS + 3;
    localparam int          HOLD_LEN   = 300;
    localparam logic        OP_UPDATE  = 1'b0;
    localparam logic        OP_SELECT  = 1'b1;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // slot[3:0], ready_req[4], level[9:5], keep_current[10]
    logic [0:0]  s_tuser  = '0;   // op[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // grant_slot[3:0], grant_level[8:4]
    logic [0:0]  m_tuser;         // granted[0]

    // predictor state
    logic                        tbl_ready [NUM_SLOTS];
    logic [prrp_pkg::LVL_W-1:0]  tbl_level [NUM_SLOTS];
    logic [prrp_pkg::SLOT_W-1:0] cur_slot;
    logic                        cur_valid;
    prrp_pkg::result_t           grant_q [$];

    int unsigned items_sent;
    int unsigned n_updates;
    int unsigned n_selects;
    int unsigned n_grants;
    int unsigned n_empty;
    int unsigned n_checked;
    int unsigned fail_cnt;
    int unsigned burst_left;

    // receiver stall pattern
    int unsigned rx_cycle;
    int unsigned rx_mode;
    int unsigned hold_left;
    int unsigned hold_seen;
    int unsigned hold_trig;

    priority_round_robin_picker_core #(
        .SLOTS  (NUM_SLOTS),
        .LEVELS (32)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    initial begin
        #(4_000_000);
        $display("tb_priority_round_robin_picker_core: FAIL");
        $finish;
    end

    // expected grant for one select; updates the predicted current slot
    task automatic predict_grant(input logic keep);
        logic                        have;
        logic                        hold;
        logic [prrp_pkg::SLOT_W-1:0] win;
        logic [prrp_pkg::SLOT_W-1:0] origin;
        logic [prrp_pkg::SLOT_W-1:0] idx;
        logic [prrp_pkg::LVL_W-1:0]  best;
        prrp_pkg::result_t           res;
        have = 1'b0;
        win  = '0;
        best = '0;
        hold = keep && cur_valid;
        if (hold && tbl_ready[cur_slot]) begin
            have = 1'b1;
            win  = cur_slot;
            best = tbl_level[cur_slot];
        end
        origin = cur_valid ? cur_slot : prrp_pkg::SLOT_W'(NUM_SLOTS - 1);
        for (int k = 1; k <= NUM_SLOTS; k++) begin
            idx = origin + prrp_pkg::SLOT_W'(k);
            if (tbl_ready[idx] && !(hold && idx == cur_slot)) begin
                if (!have || tbl_level[idx] < best) begin
                    have = 1'b1;
                    win  = idx;
                    best = tbl_level[idx];
                end
            end
        end
        res = '0;
        if (have) begin
            cur_slot    = win;
            cur_valid   = 1'b1;
            res.granted = 1'b1;
            res.slot    = win;
            res.level   = best;
            n_grants++;
        end else begin
            n_empty++;
        end
        grant_q.push_back(res);
    endtask

    // offer one request, wait for its acceptance, then predict
    task automatic send_request(input logic op, input logic [3:0] slot, input logic rdy,
                                input logic [4:0] lvl, input logic keep);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, keep, lvl, rdy, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        items_sent++;
        if (op == OP_UPDATE) begin
            tbl_ready[slot] = rdy;
            tbl_level[slot] = lvl;
            n_updates++;
        end else begin
            n_selects++;
            predict_grant(keep);
        end
    endtask

    task automatic write_slot(input logic [3:0] slot, input logic rdy, input logic [4:0] lvl);
        send_request(OP_UPDATE, slot, rdy, lvl, 1'($urandom_range(0, 1)));
    endtask

    // unused fields of a select get random values
    task automatic select_slot(input logic keep);
        send_request(OP_SELECT, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                     5'($urandom_range(0, 31)), keep);
    endtask

    task automatic test_empty_table;
        select_slot(1'b0);
        select_slot(1'b1);
    endtask

    task automatic test_extremes;
        write_slot(4'd0, 1'b1, 5'd31);
        write_slot(4'd15, 1'b1, 5'd0);
        select_slot(1'b0);
        select_slot(1'b1);
        // current slot gone, keep has nothing to hold
        write_slot(4'd15, 1'b0, 5'd0);
        select_slot(1'b1);
    endtask

    task automatic test_tie_rotation;
        write_slot(4'd3, 1'b1, 5'd5);
        write_slot(4'd7, 1'b1, 5'd5);
        write_slot(4'd12, 1'b1, 5'd5);
        select_slot(1'b0);
        select_slot(1'b0);
        select_slot(1'b0);
        select_slot(1'b1);
        // strictly lower level displaces a held current slot
        write_slot(4'd5, 1'b1, 5'd4);
        select_slot(1'b1);
    endtask

    task automatic test_nothing_ready;
        write_slot(4'd0, 1'b0, 5'd31);
        write_slot(4'd3, 1'b0, 5'd5);
        write_slot(4'd5, 1'b0, 5'd4);
        write_slot(4'd7, 1'b0, 5'd5);
        write_slot(4'd12, 1'b0, 5'd5);
        select_slot(1'b1);
        // current slot kept from before the empty select
        write_slot(4'd9, 1'b1, 5'd16);
        select_slot(1'b0);
    endtask

    task automatic random_round;
        int unsigned n;
        n = $urandom_range(0, 4);
        repeat (n) begin
            write_slot(4'($urandom_range(0, 15)), $urandom_range(0, 3) != 0,
                       5'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                               : $urandom_range(0, 31)));
        end
        if ($urandom_range(0, 40) == 0) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                write_slot(4'(i), 1'b0, 5'($urandom_range(0, 31)));
            end
        end
        select_slot(1'($urandom_range(0, 1)));
    endtask

    task automatic test_backpressure;
        hold_trig++;
        repeat (30) random_round();
    endtask

    task automatic test_random;
        while (items_sent < ITEM_GOAL) random_round();
    endtask

    // receiver: stall mode is redrawn periodically from rx_cycle, plus one long hold on request
    always @(posedge aclk) begin
        if (hold_trig != hold_seen) begin
            hold_seen = hold_trig;
            hold_left = HOLD_LEN;
        end
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
        rx_cycle++;
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_cycle % 16) < 10;
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin
        prrp_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (grant_q.size() == 0) begin
                $error("result with no pending select: granted %0d slot %0d level %0d",
                       m_tuser[0], m_tdata[3:0], m_tdata[8:4]);
                fail_cnt++;
            end else begin
                want = grant_q.pop_front();
                n_checked++;
                if (m_tuser[0] !== want.granted) begin
                    $error("granted: expected %0d, got %0d", want.granted, m_tuser[0]);
                    fail_cnt++;
                end
                if (m_tdata[3:0] !== want.slot) begin
                    $error("grant_slot: expected %0d, got %0d", want.slot, m_tdata[3:0]);
                    fail_cnt++;
                end
                if (m_tdata[8:4] !== want.level) begin
                    $error("grant_level: expected %0d, got %0d", want.level, m_tdata[8:4]);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tbl_ready[i] = 1'b0;
            tbl_level[i] = '0;
        end
        cur_slot   = '0;
        cur_valid  = 1'b0;
        items_sent = 0;
        n_updates  = 0;
        n_selects  = 0;
        n_grants   = 0;
        n_empty    = 0;
        n_checked  = 0;
        fail_cnt   = 0;
        burst_left = 0;
        rx_cycle   = 0;
        rx_mode    = 0;
        hold_left  = 0;
        hold_seen  = 0;
        hold_trig  = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_extremes();
        test_tie_rotation();
        test_nothing_ready();
        test_backpressure();
        test_random();

        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (grant_q.size() != 0) @(posedge aclk);
        repeat (2 * SELECT_LAT) @(posedge aclk);

        $display("covered %0d requests: %0d slot updates, %0d selects (%0d granted, %0d empty)",
                 items_sent, n_updates, n_selects, n_grants, n_empty);
        $display("%0d results checked, including a %0d-cycle output hold", n_checked, HOLD_LEN);
        if (fail_cnt == 0) begin
            $display("tb_priority_round_robin_picker_core: PASS");
        end else begin
            $display("tb_priority_round_robin_picker_core: FAIL");
        end
        $finish;
    end

endmodule
